>>> rtl/host_power_cycle_sequencer_unit_assert.svh
// assertion macros for the host power cycle sequencer checker
// no dependencies; included by the checker file
`ifndef HOST_POWER_CYCLE_SEQUENCER_UNIT_ASSERT_SVH
`define HOST_POWER_CYCLE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define HPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hpcs_pkg.sv
// shared types and constants for the host power cycle sequencer
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package hpcs_pkg;

    typedef struct packed {
        logic       start_request;
        logic       reset_low;
        logic [1:0] host_state;
        logic       sleep5_low;
        logic       switch_good;
    } t_hpcs_in;

    typedef struct packed {
        logic       button_level;
        logic       switch_on;
        logic       busy_res;
        logic [2:0] status;
    } t_hpcs_out;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORCEOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS  = 3'd6;

    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_DONE        = 3'd1;
    localparam logic [2:0] ST_FORCEOFF_TO = 3'd2;
    localparam logic [2:0] ST_DOWN_TO     = 3'd3;
    localparam logic [2:0] ST_SKIPPED     = 3'd4;
    localparam logic [2:0] ST_UP_TO       = 3'd5;
    localparam logic [2:0] ST_IGNORED     = 3'd6;

    localparam logic [1:0] HS_S0 = 2'd0;
    localparam logic [1:0] HS_S5 = 2'd1;

    localparam int OPT_SW_PRESENT = 0;
    localparam int OPT_S5_GATE    = 1;
    localparam int OPT_SW_FIRST   = 2;

endpackage

`default_nettype wire

>>> rtl/host_power_cycle_sequencer_unit.sv
// host power cycle sequencer: one poll tick in, one status word out
// the result word is registered when the tick word is accepted and shows in the next cycle
// throughput: one word per cycle while the output is not stalled, limited by the phase/timer update loop
// reset: synchronous active low; idle phase, timer zero, button released,
// switch powered, registers at their defaults
`timescale 1ns / 1ps
`default_nettype none

module host_power_cycle_sequencer_unit #(
    parameter int TIMER_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire hpcs_pkg::t_hpcs_in              i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output hpcs_pkg::t_hpcs_out                  o_out_data,
    input  wire                                  i_cfg_we,
    input  wire [hpcs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [hpcs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CW = TIMER_BITS + 16;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FORCEOFF, PH_DOWNWAIT, PH_SWOFF,
        PH_DWELL, PH_SWON, PH_PULSE, PH_UPWAIT
    } t_phase;

    logic [15:0] r_forceoff, r_down, r_switch, r_dwell, r_up;
    logic [7:0]  r_pulse;
    logic [2:0]  r_options;

    t_phase                  r_phase, n_phase;
    logic [TIMER_BITS-1:0]   r_tick, n_tick;
    logic                    r_button, n_button;
    logic                    r_switch_on, n_switch_on;
    logic                    r_out_valid, n_out_valid;
    hpcs_pkg::t_hpcs_out     r_out, n_out;

    logic        w_in_acc;
    logic [15:0] w_limit;
    logic        w_sat;
    logic        w_hit;
    logic        w_down;
    logic        w_sw_present;
    logic [2:0]  w_status;
    logic [TIMER_BITS-1:0] w_tick_inc;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forceoff <= 16'd1000;
            r_down     <= 16'd1000;
            r_switch   <= 16'd500;
            r_dwell    <= 16'd500;
            r_pulse    <= 8'd15;
            r_up       <= 16'd3000;
            r_options  <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hpcs_pkg::CFG_FORCEOFF: r_forceoff <= i_cfg_data;
                hpcs_pkg::CFG_DOWN:     r_down     <= i_cfg_data;
                hpcs_pkg::CFG_SWITCH:   r_switch   <= i_cfg_data;
                hpcs_pkg::CFG_DWELL:    r_dwell    <= i_cfg_data;
                hpcs_pkg::CFG_PULSE:    r_pulse    <= i_cfg_data[7:0];
                hpcs_pkg::CFG_UP:       r_up       <= i_cfg_data;
                hpcs_pkg::CFG_OPTIONS:  r_options  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // limit of the current wait, one shared compare
    always_comb begin
        case (r_phase)
            PH_FORCEOFF:       w_limit = r_forceoff;
            PH_DOWNWAIT:       w_limit = r_down;
            PH_SWOFF, PH_SWON: w_limit = r_switch;
            PH_DWELL:          w_limit = r_dwell;
            PH_PULSE:          w_limit = 16'(r_pulse);
            PH_UPWAIT:         w_limit = r_up;
            default:           w_limit = '0;
        endcase
    end

    assign w_sat        = (r_tick == {TIMER_BITS{1'b1}});
    assign w_hit        = (CW'(r_tick) >= CW'(w_limit)) || w_sat;
    assign w_tick_inc   = w_sat ? r_tick : r_tick + TIMER_BITS'(1);
    assign w_sw_present = r_options[hpcs_pkg::OPT_SW_PRESENT];
    assign w_down       = r_options[hpcs_pkg::OPT_S5_GATE]
                        ? i_in_data.sleep5_low
                        : (i_in_data.host_state == hpcs_pkg::HS_S5);

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_button    = r_button;
        n_switch_on = r_switch_on;
        w_status    = hpcs_pkg::ST_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (i_in_data.start_request) begin
                    n_phase  = PH_FORCEOFF;
                    n_tick   = '0;
                    n_button = 1'b0;
                end
            end
            PH_FORCEOFF: begin
                if (i_in_data.reset_low || (i_in_data.host_state != hpcs_pkg::HS_S0)) begin
                    n_button = 1'b1;
                    n_phase  = PH_DOWNWAIT;
                    n_tick   = '0;
                end else if (w_hit) begin
                    n_button = 1'b1;
                    n_phase  = PH_IDLE;
                    n_tick   = '0;
                    w_status = hpcs_pkg::ST_FORCEOFF_TO;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_DOWNWAIT: begin
                if (w_down) begin
                    n_tick = '0;
                    if (w_sw_present) begin
                        n_switch_on = 1'b0;
                        n_phase     = PH_SWOFF;
                    end else begin
                        n_phase = PH_DWELL;
                    end
                end else if (w_hit) begin
                    n_phase  = PH_IDLE;
                    n_tick   = '0;
                    w_status = hpcs_pkg::ST_DOWN_TO;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_SWOFF: begin
                if (!i_in_data.switch_good || w_hit) begin
                    n_phase = PH_DWELL;
                    n_tick  = '0;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_DWELL, PH_SWON: begin
                if (r_phase == PH_DWELL && w_hit && w_sw_present
                    && r_options[hpcs_pkg::OPT_SW_FIRST]) begin
                    n_switch_on = 1'b1;
                    n_phase     = PH_SWON;
                    n_tick      = '0;
                end else if (w_hit || (r_phase == PH_SWON && i_in_data.switch_good)) begin
                    // re-check that the host is still down
                    if (!w_down) begin
                        n_phase  = PH_IDLE;
                        n_tick   = '0;
                        w_status = hpcs_pkg::ST_SKIPPED;
                    end else begin
                        n_phase  = PH_PULSE;
                        n_tick   = TIMER_BITS'(1);
                        n_button = 1'b0;
                    end
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_PULSE: begin
                if (w_hit) begin
                    n_button = 1'b1;
                    n_phase  = PH_UPWAIT;
                    n_tick   = '0;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            PH_UPWAIT: begin
                if (i_in_data.host_state == hpcs_pkg::HS_S0) begin
                    n_phase  = PH_IDLE;
                    n_tick   = '0;
                    w_status = hpcs_pkg::ST_DONE;
                end else if (w_hit) begin
                    n_phase  = PH_IDLE;
                    n_tick   = '0;
                    w_status = hpcs_pkg::ST_UP_TO;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            default: begin
                n_phase  = PH_IDLE;
                n_tick   = '0;
                n_button = 1'b1;
            end
        endcase

        if (w_status == hpcs_pkg::ST_NONE && i_in_data.start_request && r_phase != PH_IDLE) begin
            w_status = hpcs_pkg::ST_IGNORED;
        end

        n_out.button_level = n_button;
        n_out.switch_on    = n_switch_on;
        n_out.busy_res     = (n_phase != PH_IDLE);
        n_out.status       = w_status;

        if (w_in_acc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_button    <= 1'b1;
            r_switch_on <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_button    <= n_button;
                r_switch_on <= n_switch_on;
            end
        end
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hpcs_checker.sv
// port-level checker for the host power cycle sequencer, bound to the top level
// depends on hpcs_pkg and host_power_cycle_sequencer_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "host_power_cycle_sequencer_unit_assert.svh"

module hpcs_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_in_stall,
    input wire hpcs_pkg::t_hpcs_out       o_out_data,
    input wire                            o_out_valid,
    input wire                            i_out_stall
);

    logic w_end_code;

    // status codes that close a cycle
    assign w_end_code = o_out_data.status inside {hpcs_pkg::ST_DONE,
                                                  hpcs_pkg::ST_FORCEOFF_TO,
                                                  hpcs_pkg::ST_DOWN_TO,
                                                  hpcs_pkg::ST_SKIPPED,
                                                  hpcs_pkg::ST_UP_TO};

    `HPCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled output word changed")
    `HPCS_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, o_in_stall, o_out_valid,
        "input stalled with empty output register")
    `HPCS_ASSERT_NOW(a_end_not_busy, i_clk, i_rst_n, o_out_valid && w_end_code,
        !o_out_data.busy_res, "ending status while still busy")
    `HPCS_ASSERT_NOW(a_idle_released, i_clk, i_rst_n, o_out_valid && !o_out_data.busy_res,
        o_out_data.button_level, "button pressed while idle")

endmodule

bind host_power_cycle_sequencer_unit hpcs_checker u_hpcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_data  (o_out_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

>>> verif/host_power_cycle_sequencer_unit_tb.sv
// testbench for host_power_cycle_sequencer_unit: a directed table, then random poll ticks
// every result word is checked, against the row's typed word or an in-bench model of the power cycle sequence
// depends on hpcs_pkg and host_power_cycle_sequencer_unit
`timescale 1ns / 1ps

module host_power_cycle_sequencer_unit_tb;

    localparam logic [1:0] HS_OTHER = 2'd2;
    localparam logic [1:0] HS_SPARE = 2'd3;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam int N_PHASES = 6;
    localparam int N_PER_PHASE = 250;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_FORCEOFF, SEQ_DOWNWAIT, SEQ_SWOFF,
        SEQ_DWELL, SEQ_SWON, SEQ_PULSE, SEQ_UPWAIT
    } t_seq_phase;

    typedef struct packed {
        hpcs_pkg::t_hpcs_in  tick;
        logic                typed;
        hpcs_pkg::t_hpcs_out want;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    hpcs_pkg::t_hpcs_in             i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    hpcs_pkg::t_hpcs_out            o_out_data;
    logic                           i_cfg_we;
    logic [hpcs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [hpcs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // model copy of the sequencer
    t_seq_phase  seq_phase;
    logic [15:0] seq_timer;
    logic        seq_button;
    logic        seq_switch;
    logic [15:0] lim_forceoff, lim_down, lim_switch, lim_dwell, lim_up;
    logic [7:0]  pulse_width;
    logic [2:0]  opt_bits;

    hpcs_pkg::t_hpcs_out status_words_due[$];
    hpcs_pkg::t_hpcs_out predicted;
    logic                row_typed;
    hpcs_pkg::t_hpcs_out row_want;
    int                  mismatches;
    bit                  tx_quiet;
    int                  rx_hold_len;

    // config for the directed walk: forceoff 1, down 1, switch 1, dwell 0, pulse 0, up 0
    t_dir_row dir_rows [0:32] = '{
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b1}, 1'b1,
          '{1'b1, 1'b1, 1'b0, hpcs_pkg::ST_NONE}},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 1'b1, 1'b1, hpcs_pkg::ST_NONE}},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 1'b1, 1'b1, hpcs_pkg::ST_IGNORED}},
        '{'{1'b0, 1'b1, hpcs_pkg::HS_S0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_SPARE,        1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b0}, 1'b1,
          '{1'b1, 1'b1, 1'b0, hpcs_pkg::ST_FORCEOFF_TO}},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b0, 1'b0}, 1'b1,
          '{1'b1, 1'b1, 1'b0, hpcs_pkg::ST_DOWN_TO}},
        '{'{1'b1, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b1, 1'b1, hpcs_pkg::HS_S0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b1, hpcs_pkg::HS_S0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, hpcs_pkg::HS_S5, 1'b1, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, HS_OTHER,        1'b1, 1'b1}, 1'b0, '0}
    };

    host_power_cycle_sequencer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("host_power_cycle_sequencer_unit_tb: errors");
        $finish;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void enter_phase(t_seq_phase p);
        seq_phase = p;
        seq_timer = '0;
    endfunction

    function automatic bit timer_done(logic [15:0] limit);
        return seq_timer >= limit || seq_timer == TIMER_MAX;
    endfunction

    function automatic void bump_timer();
        if (seq_timer != TIMER_MAX) seq_timer = seq_timer + 16'd1;
    endfunction

    function automatic bit host_gone(logic [1:0] hs, logic s5);
        if (opt_bits[hpcs_pkg::OPT_S5_GATE]) return s5;
        return hs == hpcs_pkg::HS_S5;
    endfunction

    // host must still be down before the power-up press
    function automatic logic [2:0] recheck_host(logic [1:0] hs, logic s5);
        if (!host_gone(hs, s5)) begin
            enter_phase(SEQ_IDLE);
            return hpcs_pkg::ST_SKIPPED;
        end
        enter_phase(SEQ_PULSE);
        seq_timer = 16'd1;
        seq_button = 1'b0;
        return hpcs_pkg::ST_NONE;
    endfunction

    function automatic hpcs_pkg::t_hpcs_out advance_sequencer(hpcs_pkg::t_hpcs_in w);
        hpcs_pkg::t_hpcs_out r;
        logic [2:0] st;
        logic busy_req;
        logic sw_present;
        st = hpcs_pkg::ST_NONE;
        busy_req = w.start_request && seq_phase != SEQ_IDLE;
        sw_present = opt_bits[hpcs_pkg::OPT_SW_PRESENT];
        case (seq_phase)
            SEQ_IDLE: begin
                if (w.start_request) begin
                    enter_phase(SEQ_FORCEOFF);
                    seq_button = 1'b0;
                end
            end
            SEQ_FORCEOFF: begin
                if (w.reset_low || w.host_state != hpcs_pkg::HS_S0) begin
                    seq_button = 1'b1;
                    enter_phase(SEQ_DOWNWAIT);
                end else if (timer_done(lim_forceoff)) begin
                    seq_button = 1'b1;
                    enter_phase(SEQ_IDLE);
                    st = hpcs_pkg::ST_FORCEOFF_TO;
                end else begin
                    bump_timer();
                end
            end
            SEQ_DOWNWAIT: begin
                if (host_gone(w.host_state, w.sleep5_low)) begin
                    if (sw_present) begin
                        seq_switch = 1'b0;
                        enter_phase(SEQ_SWOFF);
                    end else begin
                        enter_phase(SEQ_DWELL);
                    end
                end else if (timer_done(lim_down)) begin
                    enter_phase(SEQ_IDLE);
                    st = hpcs_pkg::ST_DOWN_TO;
                end else begin
                    bump_timer();
                end
            end
            SEQ_SWOFF: begin
                if (!w.switch_good || timer_done(lim_switch)) enter_phase(SEQ_DWELL);
                else bump_timer();
            end
            SEQ_DWELL: begin
                if (timer_done(lim_dwell)) begin
                    if (sw_present && opt_bits[hpcs_pkg::OPT_SW_FIRST]) begin
                        seq_switch = 1'b1;
                        enter_phase(SEQ_SWON);
                    end else begin
                        st = recheck_host(w.host_state, w.sleep5_low);
                    end
                end else begin
                    bump_timer();
                end
            end
            SEQ_SWON: begin
                if (w.switch_good || timer_done(lim_switch))
                    st = recheck_host(w.host_state, w.sleep5_low);
                else
                    bump_timer();
            end
            SEQ_PULSE: begin
                if (timer_done({8'd0, pulse_width})) begin
                    seq_button = 1'b1;
                    enter_phase(SEQ_UPWAIT);
                end else begin
                    bump_timer();
                end
            end
            SEQ_UPWAIT: begin
                if (w.host_state == hpcs_pkg::HS_S0) begin
                    enter_phase(SEQ_IDLE);
                    st = hpcs_pkg::ST_DONE;
                end else if (timer_done(lim_up)) begin
                    enter_phase(SEQ_IDLE);
                    st = hpcs_pkg::ST_UP_TO;
                end else begin
                    bump_timer();
                end
            end
            default: begin
                enter_phase(SEQ_IDLE);
                seq_button = 1'b1;
            end
        endcase
        if (st == hpcs_pkg::ST_NONE && busy_req) st = hpcs_pkg::ST_IGNORED;
        r.button_level = seq_button;
        r.switch_on    = seq_switch;
        r.busy_res     = seq_phase != SEQ_IDLE;
        r.status       = st;
        return r;
    endfunction

    function automatic void check_word(hpcs_pkg::t_hpcs_out want, hpcs_pkg::t_hpcs_out got);
        if (got.button_level !== want.button_level) begin
            $error("button_level: expected %0d, got %0d", want.button_level, got.button_level);
            mismatches++;
        end
        if (got.switch_on !== want.switch_on) begin
            $error("switch_on: expected %0d, got %0d", want.switch_on, got.switch_on);
            mismatches++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
    endfunction

    // host behavior that mostly follows the sequence, with some noise
    function automatic hpcs_pkg::t_hpcs_in pick_tick();
        hpcs_pkg::t_hpcs_in w;
        bit down;
        w.start_request = (seq_phase == SEQ_IDLE) ? roll(40) : roll(5);
        w.reset_low = 1'b0;
        w.switch_good = 1'($urandom_range(0, 1));
        w.sleep5_low = 1'($urandom_range(0, 1));
        if (roll(10)) begin
            w.reset_low = 1'($urandom_range(0, 1));
            w.host_state = 2'($urandom_range(0, 3));
            return w;
        end
        case (seq_phase)
            SEQ_FORCEOFF: down = roll(35);
            SEQ_DOWNWAIT: down = roll(35);
            SEQ_SWON:     down = roll(85);
            SEQ_UPWAIT:   down = 1'b0;
            default:      down = roll(85);
        endcase
        if (down) begin
            w.host_state = hpcs_pkg::HS_S5;
            w.sleep5_low = 1'b1;
        end else begin
            w.host_state = roll(50) ? hpcs_pkg::HS_S0 : 2'($urandom_range(2, 3));
            w.sleep5_low = 1'b0;
        end
        case (seq_phase)
            SEQ_FORCEOFF: begin
                if (down && roll(40)) begin
                    w.reset_low = 1'b1;
                    w.host_state = hpcs_pkg::HS_S0;
                end else if (!down) begin
                    w.host_state = hpcs_pkg::HS_S0;
                end else begin
                    w.host_state = 2'($urandom_range(1, 3));
                end
            end
            SEQ_SWOFF: w.switch_good = !roll(40);
            SEQ_SWON: w.switch_good = roll(40);
            SEQ_UPWAIT: begin
                w.host_state = roll(30) ? hpcs_pkg::HS_S0 : 2'($urandom_range(1, 3));
                w.sleep5_low = 1'b1;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_limit();
        return roll(12) ? 16'($urandom_range(16, 60)) : 16'($urandom_range(0, 10));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted = advance_sequencer(i_in_data);
                status_words_due.push_back(row_typed ? row_want : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (status_words_due.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    check_word(status_words_due.pop_front(), o_out_data);
                end
            end
        end
    end

    // receiver side: random stall bursts, quiet stretches and one long hold
    initial begin : rx_side
        int burst;
        int quiet_left;
        bit quiet;
        burst = 0;
        quiet_left = 0;
        quiet = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_left == 0) begin
                quiet = roll(25);
                quiet_left = 100;
            end
            quiet_left--;
            if (rx_hold_len != 0) begin
                rx_hold_len--;
                i_out_stall = 1'b1;
            end else if (burst != 0) begin
                burst--;
                i_out_stall = 1'b1;
            end else if (!quiet && roll(20)) begin
                burst = roll(90) ? $urandom_range(0, 2) : $urandom_range(9, 29);
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic write_reg(logic [hpcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [hpcs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        case (idx)
            hpcs_pkg::CFG_FORCEOFF: lim_forceoff = data;
            hpcs_pkg::CFG_DOWN:     lim_down = data;
            hpcs_pkg::CFG_SWITCH:   lim_switch = data;
            hpcs_pkg::CFG_DWELL:    lim_dwell = data;
            hpcs_pkg::CFG_PULSE:    pulse_width = data[7:0];
            hpcs_pkg::CFG_UP:       lim_up = data;
            hpcs_pkg::CFG_OPTIONS:  opt_bits = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_settings(int p);
        logic [7:0] pw;
        logic [2:0] opts;
        opts = 3'($urandom_range(0, 7));
        pw = 8'($urandom_range(0, 5));
        if (p == 0) opts = 3'b000;
        if (p == 1) opts = 3'b011;
        if (p == 0) begin
            write_reg(hpcs_pkg::CFG_FORCEOFF, '0);
            write_reg(hpcs_pkg::CFG_DOWN, '0);
            write_reg(hpcs_pkg::CFG_SWITCH, '0);
            write_reg(hpcs_pkg::CFG_DWELL, '0);
            write_reg(hpcs_pkg::CFG_UP, '0);
            pw = 8'd0;
        end else if (p == 2) begin
            write_reg(hpcs_pkg::CFG_FORCEOFF, '1);
            write_reg(hpcs_pkg::CFG_DOWN, '1);
            write_reg(hpcs_pkg::CFG_SWITCH, '1);
            write_reg(hpcs_pkg::CFG_DWELL, '1);
            write_reg(hpcs_pkg::CFG_UP, '1);
            pw = 8'd255;
        end else begin
            write_reg(hpcs_pkg::CFG_FORCEOFF, pick_limit());
            write_reg(hpcs_pkg::CFG_DOWN, pick_limit());
            write_reg(hpcs_pkg::CFG_SWITCH, pick_limit());
            write_reg(hpcs_pkg::CFG_DWELL, pick_limit());
            write_reg(hpcs_pkg::CFG_UP, pick_limit());
        end
        // upper data bits are random: only the register width counts
        write_reg(hpcs_pkg::CFG_PULSE, {8'($urandom), pw});
        write_reg(hpcs_pkg::CFG_OPTIONS, {13'($urandom), opts});
        i_cfg_we = 1'b0;
    endtask

    // holds the word until accepted, returns at the following falling edge
    task automatic send_tick(hpcs_pkg::t_hpcs_in w, logic typed, hpcs_pkg::t_hpcs_out want);
        i_in_valid = 1'b1;
        i_in_data = w;
        row_typed = typed;
        row_want = want;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        int gap;
        gap = 0;
        if (!tx_quiet && roll(25))
            gap = roll(90) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        while (status_words_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = hpcs_pkg::CFG_FORCEOFF;
        i_cfg_data = '0;
        row_typed = 1'b0;
        row_want = '0;
        mismatches = 0;
        tx_quiet = 1'b0;
        rx_hold_len = 0;
        lim_forceoff = 16'd1000;
        lim_down = 16'd1000;
        lim_switch = 16'd500;
        lim_dwell = 16'd500;
        pulse_width = 8'd15;
        lim_up = 16'd3000;
        opt_bits = 3'b001;
        seq_phase = SEQ_IDLE;
        seq_timer = '0;
        seq_button = 1'b1;
        seq_switch = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_reg(hpcs_pkg::CFG_FORCEOFF, 16'd1);
        write_reg(hpcs_pkg::CFG_DOWN, 16'd1);
        write_reg(hpcs_pkg::CFG_SWITCH, 16'd1);
        write_reg(hpcs_pkg::CFG_DWELL, 16'd0);
        write_reg(hpcs_pkg::CFG_PULSE, 16'd0);
        write_reg(hpcs_pkg::CFG_UP, 16'd0);
        write_reg(hpcs_pkg::CFG_OPTIONS, 16'd7);
        i_cfg_we = 1'b0;
        foreach (dir_rows[r]) begin
            send_tick(dir_rows[r].tick, dir_rows[r].typed, dir_rows[r].want);
            pause_sender();
        end

        for (int p = 0; p < N_PHASES; p++) begin
            i_in_valid = 1'b0;
            wait_for_results();
            load_settings(p);
            for (int k = 0; k < N_PER_PHASE; k++) begin
                if (k % 50 == 0) tx_quiet = roll(25);
                if (p == 1 && k == 30) rx_hold_len = 150;
                if (p == 3 && k == 120) begin
                    i_in_valid = 1'b0;
                    wait_for_results();
                end
                send_tick(pick_tick(), 1'b0, '0);
                pause_sender();
            end
        end

        i_in_valid = 1'b0;
        wait_for_results();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && status_words_due.size() == 0)
            $display("host_power_cycle_sequencer_unit_tb: clean");
        else
            $display("host_power_cycle_sequencer_unit_tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hpcs_pkg.sv
rtl/host_power_cycle_sequencer_unit.sv
rtl/hpcs_checker.sv
verif/host_power_cycle_sequencer_unit_tb.sv
